// File: src/lrk_pkg.sv
// ----------------------------------------------------------------------------
// lrk_pkg - shared types, constants and helpers
// Fixed-point format, register map and saturating helpers for the Lorenz
// RK4 integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package lrk_pkg;

  localparam int WORD_BITS  = 32;  // Q12.20 word
  localparam int FRAC_BITS  = 20;
  localparam int SUM_BITS   = 35;  // k1 + 2k2 + 2k3 + k4, exact
  localparam int ACC_BITS   = 67;  // h * weighted sum, exact
  localparam int RK_DIV     = 6;
  localparam int DIV_PAD    = 40;  // dividend padded to whole digit groups
  localparam int DIV_DIGITS = 8;   // quotient bits per cycle
  localparam int DIV_CYCLES = DIV_PAD / DIV_DIGITS;
  localparam int DIV_CNT_BITS = 3;

  // rounding bias for the increment: (RK_DIV/2) << FRAC_BITS
  localparam logic [ACC_BITS-1:0] INC_BIAS = ACC_BITS'(RK_DIV / 2) << FRAC_BITS;

  localparam logic signed [WORD_BITS-1:0] SIGMA_RST = 32'sd10485760;
  localparam logic signed [WORD_BITS-1:0] RHO_RST   = 32'sd29360128;
  localparam logic signed [WORD_BITS-1:0] BETA_RST  = 32'sd2796203;
  localparam logic [WORD_BITS-2:0]        STEP_RST  = 31'd10486;
  localparam logic [15:0]                 INTV_RST  = 16'd1;

  typedef enum logic [2:0] {
    REG_SIGMA = 3'd0,
    REG_RHO   = 3'd1,
    REG_BETA  = 3'd2,
    REG_STEP  = 3'd3,
    REG_INTV  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        sat;
  } sat_word_t;

  function automatic sat_word_t clamp_word(input logic signed [WORD_BITS:0] v);
    sat_word_t r;
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r.sat = 1'b1;
      r.val = v[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    end else begin
      r.sat = 1'b0;
      r.val = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic sat_word_t add_sat(input logic signed [WORD_BITS-1:0] a,
                                        input logic signed [WORD_BITS-1:0] b,
                                        input logic                        sub);
    logic signed [WORD_BITS:0] w;
    w = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
            : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
    return clamp_word(w);
  endfunction

  function automatic logic [WORD_BITS-1:0] mag_word(input logic signed [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (WORD_BITS'(0) - v) : v;
  endfunction

endpackage

`default_nettype wire

// File: src/lrk_mul.sv
// ----------------------------------------------------------------------------
// lrk_mul - shared multiplier
// Unsigned 32x32 product register, then round-half-away and clip to the
// signed word in a second register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lrk_mul
  import lrk_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic [WORD_BITS-1:0]        a_mag,
  input  wire logic [WORD_BITS-1:0]        b_mag,
  input  wire logic                        neg,
  input  wire logic                        half,   // extra divide by two (h/2)
  output logic      [2*WORD_BITS-1:0]      prod,
  output logic signed [WORD_BITS-1:0]      res,
  output logic                             res_sat
);

  logic [2*WORD_BITS-1:0]     prod_r;
  logic                       neg_r;
  logic                       half_r;
  logic signed [WORD_BITS-1:0] res_r;
  logic                       res_sat_r;

  logic [2*WORD_BITS-1:0]     rnd;
  logic [2*WORD_BITS-1:0]     shifted;
  logic [WORD_BITS:0]         lim;
  logic [WORD_BITS:0]         q;
  logic signed [WORD_BITS-1:0] res_nxt;
  logic                       sat_nxt;

  always_comb begin
    rnd     = prod_r + (half_r ? ((2*WORD_BITS)'(1) << FRAC_BITS)
                               : ((2*WORD_BITS)'(1) << (FRAC_BITS - 1)));
    shifted = half_r ? (rnd >> (FRAC_BITS + 1)) : (rnd >> FRAC_BITS);
    lim     = {1'b0, neg_r, {(WORD_BITS-1){~neg_r}}};
    if (shifted > (2*WORD_BITS)'(lim)) begin
      sat_nxt = 1'b1;
      q       = lim;
    end else begin
      sat_nxt = 1'b0;
      q       = shifted[WORD_BITS:0];
    end
    res_nxt = WORD_BITS'(neg_r ? ((WORD_BITS+1)'(0) - q) : q);
  end

  always_ff @(posedge clk) begin
    prod_r    <= a_mag * b_mag;
    neg_r     <= neg;
    half_r    <= half;
    res_r     <= res_nxt;
    res_sat_r <= sat_nxt;
  end

  assign prod    = prod_r;
  assign res     = res_r;
  assign res_sat = res_sat_r;

endmodule

`default_nettype wire

// File: src/lrk_div6.sv
// ----------------------------------------------------------------------------
// lrk_div6 - divide by six
// Restoring division by the constant six, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lrk_div6
  import lrk_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SUM_BITS-1:0] dividend,
  output logic                     busy,
  output logic [SUM_BITS-1:0]      quot
);

  logic [DIV_PAD-1:0]      sh_r;
  logic [2:0]              rem_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;

  logic [DIV_PAD-1:0] s;
  logic [2:0]         r;
  logic [3:0]         t4;

  always_comb begin
    s = sh_r;
    r = rem_r;
    for (int j = 0; j < DIV_DIGITS; j++) begin
      t4 = {r, s[DIV_PAD-1]};
      s  = {s[DIV_PAD-2:0], 1'b0};
      if (t4 >= 4'(RK_DIV)) begin
        r    = 3'(t4 - 4'(RK_DIV));
        s[0] = 1'b1;
      end else begin
        r = t4[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_BITS'(DIV_CYCLES);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= DIV_PAD'(dividend);
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      sh_r  <= s;
      rem_r <= r;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = sh_r[SUM_BITS-1:0];

endmodule

`default_nettype wire

// File: src/lorenz_rk4_integrator.sv
// ----------------------------------------------------------------------------
// lorenz_rk4_integrator - fixed-point Lorenz flow, classical RK4
// Flow: a load item goes to the done state and gives its result once the
//   output slot is free; a step item evaluates four velocities, forming a
//   stage point after each of the first three, then each axis increment.
// Throughput: one item at a time; the next is taken once the sequencer is idle.
// Reset: rst_n synchronous, active low; state to the origin, registers to their
//   defaults, step counter to zero, output channel empty.
// ----------------------------------------------------------------------------
`default_nettype none

module lorenz_rk4_integrator
  import lrk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // start_x [31:0], start_y [63:32], start_z [95:64]
  input  wire logic [0:0]  in_tuser,   // operation [0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  output logic [1:0]       out_tuser,  // sample_mark [0], saturated [1]
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Sequencer: V0..V7 evaluate one velocity through the shared multiplier
  // (pipelined) and fold it into the weighted sum; P1..P4 form the
  // next stage point; F0..F5 form each axis increment and rotate the axes.
  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_V0   = 20'h00002,
    ST_V1   = 20'h00004,
    ST_V2   = 20'h00008,
    ST_V3   = 20'h00010,
    ST_V4   = 20'h00020,
    ST_V5   = 20'h00040,
    ST_V6   = 20'h00080,
    ST_V7   = 20'h00100,
    ST_P1   = 20'h00200,
    ST_P2   = 20'h00400,
    ST_P3   = 20'h00800,
    ST_P4   = 20'h01000,
    ST_F0   = 20'h02000,
    ST_F1   = 20'h04000,
    ST_F2   = 20'h08000,
    ST_F3   = 20'h10000,
    ST_F4   = 20'h20000,
    ST_F5   = 20'h40000,
    ST_DONE = 20'h80000
  } state_t;

  localparam logic [1:0] FIRST_STAGE = 2'd0;
  localparam logic [1:0] FULL_STAGE  = 2'd2;  // k4 point uses the whole step
  localparam logic [1:0] LAST_STAGE  = 2'd3;
  localparam logic [1:0] LAST_AXIS   = 2'd2;

  state_t state_r, state_nxt;

  // configuration
  logic signed [WORD_BITS-1:0] sigma_r, rho_r, beta_r;
  logic [WORD_BITS-2:0]        h_r;
  logic [15:0]                 intv_r;

  // integrator state
  logic signed [WORD_BITS-1:0] cur_x_r, cur_y_r, cur_z_r;
  logic [15:0]                 steps_r;
  logic [1:0]                  stage_r;
  logic [1:0]                  ci_r;
  logic                        sat_r;
  logic                        is_load_r;

  // working registers
  logic signed [WORD_BITS-1:0] tx_r, ty_r, tz_r;
  logic signed [WORD_BITS-1:0] d_r, tt_r, mm_r;
  logic signed [WORD_BITS-1:0] k0_r, k1_r, k2_r;
  logic signed [SUM_BITS-1:0]  s0_r, s1_r, s2_r;
  logic [ACC_BITS-1:0]         acc_r;
  logic                        neg_r;
  logic                        ovf_r;

  logic                        out_tvalid_r;
  logic [95:0]                 out_tdata_r;
  logic [1:0]                  out_tuser_r;

  // datapath nets
  logic signed [WORD_BITS-1:0] qx, qy, qz;
  logic signed [WORD_BITS-1:0] op_a, op_b, h_word;
  logic                        raw_mode;
  logic [WORD_BITS-1:0]        raw_b;
  logic                        mul_half;
  logic [WORD_BITS-1:0]        mul_a_mag, mul_b_mag;
  logic                        mul_neg;
  logic [2*WORD_BITS-1:0]      mul_prod;
  logic signed [WORD_BITS-1:0] mul_res;
  logic                        mul_res_sat;

  logic signed [WORD_BITS-1:0] add_a, add_b;
  logic                        add_sub, add_use, res_use;
  sat_word_t                   add_res;

  logic [SUM_BITS-1:0]         smag;
  logic [WORD_BITS:0]          lim;
  logic                        q_clip;
  logic [WORD_BITS:0]          inc_mag;
  logic signed [WORD_BITS-1:0] inc_val;
  logic [ACC_BITS-1:0]         rnd;
  logic                        sat_ev;

  logic                        div_start, div_busy;
  logic [SUM_BITS-1:0]         div_quot;

  logic                        in_acc, cfg_wr, out_free;
  logic [16:0]                 cnt_inc;
  logic                        cnt_hit;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign h_word     = {1'b0, h_r};
  assign div_start  = (state_r == ST_F3);
  assign rnd        = acc_r + INC_BIAS;
  assign cnt_inc    = {1'b0, steps_r} + 17'd1;
  assign cnt_hit    = cnt_inc >= {1'b0, intv_r};

  // --- shared units --------------------------------------------------------
  lrk_mul u_mul (
    .clk     (clk),
    .a_mag   (mul_a_mag),
    .b_mag   (mul_b_mag),
    .neg     (mul_neg),
    .half    (mul_half),
    .prod    (mul_prod),
    .res     (mul_res),
    .res_sat (mul_res_sat)
  );

  lrk_div6 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rnd[FRAC_BITS +: SUM_BITS]),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  // --- operand selection ---------------------------------------------------
  always_comb begin
    qx = (stage_r == FIRST_STAGE) ? cur_x_r : tx_r;
    qy = (stage_r == FIRST_STAGE) ? cur_y_r : ty_r;
    qz = (stage_r == FIRST_STAGE) ? cur_z_r : tz_r;
    op_a     = '0;
    op_b     = '0;
    raw_mode = 1'b0;
    raw_b    = '0;
    mul_half = 1'b0;
    add_a    = '0;
    add_b    = '0;
    add_sub  = 1'b0;
    add_use  = 1'b0;
    res_use  = 1'b0;

    // increment of axis 0: magnitude, limit, clip
    smag    = s0_r[SUM_BITS-1] ? (SUM_BITS'(0) - s0_r) : s0_r;
    lim     = {1'b0, neg_r, {(WORD_BITS-1){~neg_r}}};
    q_clip  = ovf_r || (div_quot > SUM_BITS'(lim));
    inc_mag = q_clip ? lim : div_quot[WORD_BITS:0];
    inc_val = WORD_BITS'(neg_r ? ((WORD_BITS+1)'(0) - inc_mag) : inc_mag);

    unique case (state_r)
      ST_V0: begin
        op_a = rho_r;  op_b = qx;
        add_a = qy;    add_b = qx;    add_sub = 1'b1; add_use = 1'b1;
      end
      ST_V1: begin
        op_a = sigma_r; op_b = d_r;
      end
      ST_V2: begin
        op_a = qx;      op_b = qz;
        add_a = mul_res; add_b = qy;  add_sub = 1'b1; add_use = 1'b1; res_use = 1'b1;
      end
      ST_V3: begin
        op_a = qx; op_b = qy; res_use = 1'b1;
      end
      ST_V4: begin
        op_a = beta_r; op_b = qz;
        add_a = tt_r;  add_b = mul_res; add_sub = 1'b1; add_use = 1'b1; res_use = 1'b1;
      end
      ST_V5: begin
        res_use = 1'b1;
      end
      ST_V6: begin
        add_a = mm_r; add_b = mul_res; add_sub = 1'b1; add_use = 1'b1; res_use = 1'b1;
      end
      ST_V7: begin
        op_a = h_word; op_b = k0_r; mul_half = (stage_r != FULL_STAGE);
      end
      ST_P1: begin
        op_a = h_word; op_b = k1_r; mul_half = (stage_r != FULL_STAGE);
      end
      ST_P2: begin
        op_a = h_word; op_b = k2_r; mul_half = (stage_r != FULL_STAGE);
        add_a = cur_x_r; add_b = mul_res; add_use = 1'b1; res_use = 1'b1;
      end
      ST_P3: begin
        add_a = cur_y_r; add_b = mul_res; add_use = 1'b1; res_use = 1'b1;
      end
      ST_P4: begin
        add_a = cur_z_r; add_b = mul_res; add_use = 1'b1; res_use = 1'b1;
      end
      ST_F0: begin
        raw_mode = 1'b1; raw_b = smag[WORD_BITS-1:0];
      end
      ST_F1: begin
        raw_mode = 1'b1; raw_b = WORD_BITS'(smag[SUM_BITS-1:WORD_BITS]);
      end
      ST_F5: begin
        add_a = cur_x_r; add_b = inc_val; add_use = 1'b1;
      end
      default: begin
      end
    endcase

    add_res   = add_sat(add_a, add_b, add_sub);
    mul_a_mag = raw_mode ? WORD_BITS'(h_r) : mag_word(op_a);
    mul_b_mag = raw_mode ? raw_b : mag_word(op_b);
    mul_neg   = !raw_mode && (op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1]);
    sat_ev    = (add_use && add_res.sat) || (res_use && mul_res_sat) ||
                ((state_r == ST_F5) && q_clip);
  end

  // --- sequencer -----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = (op_t'(in_tuser[0]) == OP_LOAD) ? ST_DONE : ST_V0;
      end
      ST_V0: state_nxt = ST_V1;
      ST_V1: state_nxt = ST_V2;
      ST_V2: state_nxt = ST_V3;
      ST_V3: state_nxt = ST_V4;
      ST_V4: state_nxt = ST_V5;
      ST_V5: state_nxt = ST_V6;
      ST_V6: state_nxt = ST_V7;
      ST_V7: state_nxt = (stage_r == LAST_STAGE) ? ST_F0 : ST_P1;
      ST_P1: state_nxt = ST_P2;
      ST_P2: state_nxt = ST_P3;
      ST_P3: state_nxt = ST_P4;
      ST_P4: state_nxt = ST_V0;
      ST_F0: state_nxt = ST_F1;
      ST_F1: state_nxt = ST_F2;
      ST_F2: state_nxt = ST_F3;
      ST_F3: state_nxt = ST_F4;
      ST_F4: if (!div_busy) begin
        state_nxt = ST_F5;
      end
      ST_F5: state_nxt = (ci_r == LAST_AXIS) ? ST_DONE : ST_F0;
      ST_DONE: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --- control, state and configuration ------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sigma_r      <= SIGMA_RST;
      rho_r        <= RHO_RST;
      beta_r       <= BETA_RST;
      h_r          <= STEP_RST;
      intv_r       <= INTV_RST;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      cur_z_r      <= '0;
      steps_r      <= '0;
      stage_r      <= '0;
      ci_r         <= '0;
      sat_r        <= 1'b0;
      is_load_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      out_tuser_r  <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        unique case (reg_idx_t'(cfg_paddr[4:2]))
          REG_SIGMA: sigma_r <= cfg_pwdata;
          REG_RHO:   rho_r   <= cfg_pwdata;
          REG_BETA:  beta_r  <= cfg_pwdata;
          REG_STEP:  h_r     <= cfg_pwdata[WORD_BITS-2:0];
          REG_INTV:  intv_r  <= cfg_pwdata[15:0];
          default: begin
          end
        endcase
      end

      if (sat_ev) begin
        sat_r <= 1'b1;
      end
      // a new result loaded below keeps the valid high
      if (out_tready && !((state_r == ST_DONE) && out_free)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: if (in_acc) begin
          sat_r   <= 1'b0;
          stage_r <= FIRST_STAGE;
          ci_r    <= '0;
          if (op_t'(in_tuser[0]) == OP_LOAD) begin
            is_load_r <= 1'b1;
            cur_x_r   <= in_tdata[31:0];
            cur_y_r   <= in_tdata[63:32];
            cur_z_r   <= in_tdata[95:64];
          end else begin
            is_load_r <= 1'b0;
          end
        end
        ST_P4: stage_r <= stage_r + 1'b1;
        ST_F5: begin
          // rotate so that axis 0 is always the one being finished
          cur_x_r <= cur_y_r;
          cur_y_r <= cur_z_r;
          cur_z_r <= add_res.val;
          ci_r    <= ci_r + 1'b1;
        end
        ST_DONE: if (out_free) begin
          out_tvalid_r <= 1'b1;
          out_tdata_r  <= {cur_z_r, cur_y_r, cur_x_r};
          if (is_load_r) begin
            out_tuser_r <= {sat_r, 1'b1};
            steps_r     <= '0;
          end else begin
            out_tuser_r <= {sat_r, cnt_hit};
            steps_r     <= cnt_hit ? 16'd0 : cnt_inc[15:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --- working registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_V0: d_r  <= add_res.val;
      ST_V2: tt_r <= add_res.val;
      ST_V3: k0_r <= mul_res;
      ST_V4: k1_r <= add_res.val;
      ST_V5: mm_r <= mul_res;
      ST_V6: k2_r <= add_res.val;
      ST_V7: begin
        // weights 1, 2, 2, 1
        if (stage_r == FIRST_STAGE) begin
          s0_r <= {{3{k0_r[WORD_BITS-1]}}, k0_r};
          s1_r <= {{3{k1_r[WORD_BITS-1]}}, k1_r};
          s2_r <= {{3{k2_r[WORD_BITS-1]}}, k2_r};
        end else if (stage_r == LAST_STAGE) begin
          s0_r <= s0_r + {{3{k0_r[WORD_BITS-1]}}, k0_r};
          s1_r <= s1_r + {{3{k1_r[WORD_BITS-1]}}, k1_r};
          s2_r <= s2_r + {{3{k2_r[WORD_BITS-1]}}, k2_r};
        end else begin
          s0_r <= s0_r + {{2{k0_r[WORD_BITS-1]}}, k0_r, 1'b0};
          s1_r <= s1_r + {{2{k1_r[WORD_BITS-1]}}, k1_r, 1'b0};
          s2_r <= s2_r + {{2{k2_r[WORD_BITS-1]}}, k2_r, 1'b0};
        end
      end
      ST_P2: tx_r <= add_res.val;
      ST_P3: ty_r <= add_res.val;
      ST_P4: tz_r <= add_res.val;
      ST_F0: neg_r <= s0_r[SUM_BITS-1];
      ST_F1: acc_r <= ACC_BITS'(mul_prod);
      ST_F2: acc_r <= acc_r + {mul_prod[SUM_BITS-1:0], {WORD_BITS{1'b0}}};
      ST_F3: ovf_r <= |rnd[ACC_BITS-1:FRAC_BITS+SUM_BITS];
      ST_F5: begin
        s0_r <= s1_r;
        s1_r <= s2_r;
      end
      default: begin
      end
    endcase
  end

  // --- register read-back --------------------------------------------------
  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[4:2]))
      REG_SIGMA: cfg_prdata = sigma_r;
      REG_RHO:   cfg_prdata = rho_r;
      REG_BETA:  cfg_prdata = beta_r;
      REG_STEP:  cfg_prdata = {1'b0, h_r};
      REG_INTV:  cfg_prdata = {16'd0, intv_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

// File: src/lrk_checker.sv
// ----------------------------------------------------------------------------
// lrk_checker - port-level checks
// Watches the channels of the integrator over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lrk_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pready
);

  // one item in flight: taking an item closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready after an item was taken");

  // a result waiting for the sink holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

  // reset leaves an empty output and an idle input side
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("reset did not empty the block");

  // register port never inserts wait states
  a_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable) |-> cfg_pready)
    else $error("configuration access stalled");

endmodule

bind lorenz_rk4_integrator lrk_checker u_lrk_checker (.*);

`default_nettype wire
